// File: rtl/ssdf_pkg.sv
// ----------------------------------------------------------------------------
// ssdf_pkg
// Shared types, codes and constants of the seven segment digit formatter.
// ----------------------------------------------------------------------------
package ssdf_pkg;

  // Display geometry
  localparam int DIGITS    = 4;
  localparam int DIG_IDX_W = $clog2(DIGITS);
  localparam int CHAR_W    = 8;
  localparam int VALUE_W   = 16;
  localparam int COL_W     = 3;
  localparam int KIND_W    = 3;
  localparam int PERIOD_W  = 16;

  // Character codes
  localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CH_A     = 8'h41;
  localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;

  // Configuration register indexes
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] CFG_BLINK_ENABLE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_BLINK_PERIOD = 1'b1;
  localparam logic [PERIOD_W-1:0]  BLINK_PERIOD_RST = 16'd100;

  // Reciprocals for division by one hundred
  // value / 100 for value < 2^16: (value * 83887) >> 23
  localparam logic [16:0] RECIP100_BIG   = 17'd83887;
  // hundreds / 100 for hundreds < 656: (hundreds * 656) >> 16
  localparam logic [9:0]  RECIP100_SMALL = 10'd656;
  localparam logic [6:0]  HUNDRED        = 7'd100;

  // Item kinds
  typedef enum logic [KIND_W-1:0] {
    KIND_TICK  = 3'd0,
    KIND_CHAR  = 3'd1,
    KIND_UDEC  = 3'd2,
    KIND_UHEX  = 3'd3,
    KIND_SDEC  = 3'd4,
    KIND_SHEX  = 3'd5,
    KIND_CLEAR = 3'd6
  } kind_t;

  // Item as it travels down the digit split pipeline
  typedef struct packed {
    kind_t              kind;
    logic [COL_W-1:0]   column;
    logic [CHAR_W-1:0]  char_code;
    logic [VALUE_W-1:0] num;
    logic               neg;
  } item_t;

  // Item with its two decimal pairs (value mod 100, value / 100 mod 100)
  typedef struct packed {
    item_t      item;
    logic [6:0] lo;
    logic [6:0] mid;
  } dec_item_t;

  // Two-digit BCD lookup for 0..99
  typedef logic [7:0] bcd_tbl_t [100];

  function automatic bcd_tbl_t build_bcd_tbl();
    bcd_tbl_t tbl;
    int       n;
    n = 0;
    for (int t = 0; t < 10; t++) begin
      for (int u = 0; u < 10; u++) begin
        tbl[n] = {4'(t), 4'(u)};
        n++;
      end
    end
    return tbl;
  endfunction

  localparam bcd_tbl_t BCD_TBL = build_bcd_tbl();

endpackage

// File: rtl/seven_segment_digit_formatter.sv
// ----------------------------------------------------------------------------
// seven_segment_digit_formatter
// Four-character display formatter with blink: ticks, character writes,
// decimal and hex number writes and clear, one result item per input item.
// ----------------------------------------------------------------------------
//  channel | direction | handshake              | payload
//  in      | input     | in_valid / in_ready    | kind, value, column, char_code
//  out     | output    | out_valid / out_ready  | pos0_char..pos3_char, lit
//  cfg     | input     | cfg_we (no wait)       | cfg_index, cfg_data
//
// One item is accepted every cycle unless a held result stalls the pipeline;
// its result passes the input register, the reciprocal multiply stages that
// split the value into decimal digit pairs and the result register.
// Reset clears the pipeline, blanks the display, sets it lit, zeroes the
// tick count and restores blink off with a period of 100.
// While a result waits on out_ready the whole pipeline holds and in_ready
// drops.
// ----------------------------------------------------------------------------
module seven_segment_digit_formatter
  import ssdf_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [KIND_W-1:0]     kind,
  input  logic [VALUE_W-1:0]    value,
  input  logic [COL_W-1:0]      column,
  input  logic [CHAR_W-1:0]     char_code,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [CHAR_W-1:0]     pos0_char,
  output logic [CHAR_W-1:0]     pos1_char,
  output logic [CHAR_W-1:0]     pos2_char,
  output logic [CHAR_W-1:0]     pos3_char,
  output logic                  lit,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  logic              advance;
  logic              in_take;
  logic              dec_valid;
  dec_item_t         dec_item;
  logic [CHAR_W-1:0] out_chars [DIGITS];

  // Advance the whole pipeline unless a result is held
  assign advance  = !out_valid || out_ready;
  assign in_ready = advance;
  assign in_take  = in_valid && advance;

  ssdf_digit_split u_split (
    .clk       (clk),
    .rst       (rst),
    .advance   (advance),
    .in_take   (in_take),
    .kind      (kind),
    .value     (value),
    .column    (column),
    .char_code (char_code),
    .dec_valid (dec_valid),
    .dec_item  (dec_item)
  );

  ssdf_display_state u_state (
    .clk       (clk),
    .rst       (rst),
    .advance   (advance),
    .dec_valid (dec_valid),
    .dec_item  (dec_item),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_valid (out_valid),
    .out_chars (out_chars),
    .out_lit   (lit)
  );

  assign pos0_char = out_chars[0];
  assign pos1_char = out_chars[1];
  assign pos2_char = out_chars[2];
  assign pos3_char = out_chars[3];

endmodule

// File: rtl/ssdf_digit_split.sv
// ----------------------------------------------------------------------------
// ssdf_digit_split
// Input register and decimal split pipeline: selects the magnitude to show
// and breaks it into two decimal pairs by reciprocal multiplication.
// ----------------------------------------------------------------------------
module ssdf_digit_split
  import ssdf_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                advance,
  input  logic                in_take,
  input  logic [KIND_W-1:0]   kind,
  input  logic [VALUE_W-1:0]  value,
  input  logic [COL_W-1:0]    column,
  input  logic [CHAR_W-1:0]   char_code,
  output logic                dec_valid,
  output dec_item_t           dec_item
);

  // Input register
  logic               s0_valid;
  kind_t              s0_kind;
  logic [VALUE_W-1:0] s0_value;
  logic [COL_W-1:0]   s0_column;
  logic [CHAR_W-1:0]  s0_char;

  // Stage 1: hundreds
  logic               s1_valid;
  item_t              s1_item;
  logic [9:0]         s1_hi;

  // Stage 2: low pair and ten-thousands quotient
  logic               s2_valid;
  item_t              s2_item;
  logic [9:0]         s2_hi;
  logic [6:0]         s2_lo;
  logic [3:0]         s2_t;

  logic [7:0]         low_byte;
  logic               is_signed;
  logic [8:0]         mag;
  item_t              s0_item;
  logic [32:0]        prod_hi;
  logic [15:0]        hi_x100;
  logic [15:0]        lo_full;
  logic [19:0]        prod_t;
  logic [9:0]         t_x100;
  logic [9:0]         mid_full;

  // Pick the magnitude: signed kinds use the low byte as two's complement
  always_comb begin
    low_byte  = s0_value[7:0];
    is_signed = (s0_kind == KIND_SDEC) || (s0_kind == KIND_SHEX);
    if (low_byte[7]) begin
      mag = 9'd256 - {1'b0, low_byte};
    end else begin
      mag = {1'b0, low_byte};
    end
    s0_item.kind      = s0_kind;
    s0_item.column    = s0_column;
    s0_item.char_code = s0_char;
    s0_item.neg       = is_signed && low_byte[7];
    s0_item.num       = is_signed ? {7'd0, mag} : s0_value;
    prod_hi           = 33'(s0_item.num) * 33'(RECIP100_BIG);
  end

  // Low pair and hundreds divided by one hundred
  always_comb begin
    hi_x100 = 16'(s1_hi) * 16'(HUNDRED);
    lo_full = s1_item.num - hi_x100;
    prod_t  = 20'(s1_hi) * 20'(RECIP100_SMALL);
  end

  // Middle pair: hundreds mod one hundred
  always_comb begin
    t_x100   = 10'(s2_t) * 10'(HUNDRED);
    mid_full = s2_hi - t_x100;
  end

  // Advance valid bits with the pipeline
  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid  <= 1'b0;
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      dec_valid <= 1'b0;
    end else if (advance) begin
      s0_valid  <= in_take;
      s1_valid  <= s0_valid;
      s2_valid  <= s1_valid;
      dec_valid <= s2_valid;
    end
  end

  // Advance payload with the pipeline
  always_ff @(posedge clk) begin
    if (advance) begin
      s0_kind      <= kind_t'(kind);
      s0_value     <= value;
      s0_column    <= column;
      s0_char      <= char_code;
      s1_item      <= s0_item;
      s1_hi        <= prod_hi[32:23];
      s2_item      <= s1_item;
      s2_hi        <= s1_hi;
      s2_lo        <= lo_full[6:0];
      s2_t         <= prod_t[19:16];
      dec_item.item <= s2_item;
      dec_item.lo   <= s2_lo;
      dec_item.mid  <= mid_full[6:0];
    end
  end

endmodule

// File: rtl/ssdf_display_state.sv
// ----------------------------------------------------------------------------
// ssdf_display_state
// Display characters, blink phase, tick counter, configuration registers
// and the result register.
// ----------------------------------------------------------------------------
module ssdf_display_state
  import ssdf_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  advance,
  input  logic                  dec_valid,
  input  dec_item_t             dec_item,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output logic                  out_valid,
  output logic [CHAR_W-1:0]     out_chars [DIGITS],
  output logic                  out_lit
);

  logic [CHAR_W-1:0]   chars      [DIGITS];
  logic [CHAR_W-1:0]   chars_next [DIGITS];
  logic [CHAR_W-1:0]   num_chars  [DIGITS];
  logic [3:0]          dig        [DIGITS];
  logic [DIGITS-1:0]   keep;
  logic                lit_phase;
  logic                lit_phase_next;
  logic [15:0]         ticks;
  logic [15:0]         ticks_next;
  logic [15:0]         ticks_inc;
  logic                blink_enable;
  logic [PERIOD_W-1:0] blink_period;
  logic [7:0]          bcd_lo;
  logic [7:0]          bcd_mid;
  logic                use_hex;
  logic                sign_here;
  item_t               it;

  assign it = dec_item.item;

  // Look up decimal digits, or take hex nibbles
  always_comb begin
    bcd_lo  = BCD_TBL[dec_item.lo];
    bcd_mid = BCD_TBL[dec_item.mid];
    use_hex = (it.kind == KIND_UHEX) || (it.kind == KIND_SHEX);
    if (use_hex) begin
      for (int i = 0; i < DIGITS; i++) begin
        dig[i] = it.num[4*i +: 4];
      end
    end else begin
      dig[0] = bcd_lo[3:0];
      dig[1] = bcd_lo[7:4];
      dig[2] = bcd_mid[3:0];
      dig[3] = bcd_mid[7:4];
    end
  end

  // Mark positions up to the top non-zero digit, then format
  always_comb begin
    keep[DIGITS-1] = (dig[DIGITS-1] != 4'd0);
    for (int i = DIGITS - 2; i >= 0; i--) begin
      keep[i] = keep[i+1] || (dig[i] != 4'd0);
    end
    keep[0] = 1'b1;
    for (int i = 0; i < DIGITS; i++) begin
      sign_here = (i > 0) ? (it.neg && keep[(i > 0) ? i - 1 : 0] && !keep[i]) : 1'b0;
      if (keep[i]) begin
        if (dig[i] >= 4'd10) begin
          num_chars[i] = CH_A + 8'(dig[i]) - 8'd10;
        end else begin
          num_chars[i] = CH_ZERO + 8'(dig[i]);
        end
      end else if (sign_here) begin
        num_chars[i] = CH_MINUS;
      end else begin
        num_chars[i] = CH_SPACE;
      end
    end
  end

  // Work out the state after this item
  always_comb begin
    chars_next     = chars;
    lit_phase_next = lit_phase;
    ticks_next     = ticks;
    ticks_inc      = (ticks == 16'hFFFF) ? ticks : ticks + 16'd1;
    case (it.kind)
      KIND_TICK: begin
        ticks_next = ticks_inc;
        if (blink_enable && (ticks_inc >= (blink_period >> 1))) begin
          ticks_next     = 16'd0;
          lit_phase_next = !lit_phase;
        end
      end
      KIND_CHAR: begin
        if (it.column < COL_W'(DIGITS)) begin
          chars_next[it.column[DIG_IDX_W-1:0]] = it.char_code;
        end
      end
      KIND_UDEC, KIND_UHEX, KIND_SDEC, KIND_SHEX: begin
        chars_next     = num_chars;
        lit_phase_next = 1'b1;
      end
      KIND_CLEAR: begin
        for (int i = 0; i < DIGITS; i++) begin
          chars_next[i] = CH_SPACE;
        end
      end
      default: begin
      end
    endcase
  end

  // Hold display state, update on each item
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < DIGITS; i++) begin
        chars[i] <= CH_SPACE;
      end
      lit_phase <= 1'b1;
      ticks     <= 16'd0;
    end else if (advance && dec_valid) begin
      chars     <= chars_next;
      lit_phase <= lit_phase_next;
      ticks     <= ticks_next;
    end
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      blink_enable <= 1'b0;
      blink_period <= BLINK_PERIOD_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_BLINK_ENABLE: blink_enable <= cfg_data[0];
        CFG_BLINK_PERIOD: blink_period <= cfg_data[PERIOD_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Result register: valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= dec_valid;
    end
  end

  // Result register: drive space while dark
  always_ff @(posedge clk) begin
    if (advance && dec_valid) begin
      for (int i = 0; i < DIGITS; i++) begin
        out_chars[i] <= lit_phase_next ? chars_next[i] : CH_SPACE;
      end
      out_lit <= lit_phase_next;
    end
  end

endmodule

// File: rtl/ssdf_checker.sv
// ----------------------------------------------------------------------------
// ssdf_checker
// Port-level checks of the seven segment digit formatter, bound to the top.
// ----------------------------------------------------------------------------
module ssdf_checker
  import ssdf_pkg::*;
(
  input logic                  clk,
  input logic                  rst,
  input logic                  in_ready,
  input logic                  out_valid,
  input logic                  out_ready,
  input logic [CHAR_W-1:0]     pos0_char,
  input logic [CHAR_W-1:0]     pos1_char,
  input logic [CHAR_W-1:0]     pos2_char,
  input logic [CHAR_W-1:0]     pos3_char,
  input logic                  lit
);

  // No result straight out of reset
  assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

  // A held result keeps its payload
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(pos0_char) && $stable(pos1_char)
      && $stable(pos2_char) && $stable(pos3_char) && $stable(lit))
    else $error("held result changed");

  // Dark phase drives all spaces
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !lit |-> pos0_char == CH_SPACE && pos1_char == CH_SPACE
      && pos2_char == CH_SPACE && pos3_char == CH_SPACE)
    else $error("dark display shows characters");

  // Input side never stalls while the result slot is free
  assert property (@(posedge clk) disable iff (rst)
    !out_valid || out_ready |-> in_ready)
    else $error("input stalled with free result slot");

endmodule

bind seven_segment_digit_formatter ssdf_checker u_ssdf_checker (.*);
